@@ rtl/cvt_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, item types and trig generator tables for the camera view transform.
package cvt_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int COORD_W        = 32;
  localparam int TAG_W          = 32;
  localparam int ANG_W          = 16;
  localparam int APB_AW         = 5;
  localparam int TAYLOR_TERMS   = 6;

  localparam logic [31:0] ANGLE_MASK   = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;
  localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN    = 32'h8000_0000;

  localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
  localparam logic [31:0] RECIP_156  = 32'(TWO_POW_32 / 156);
  localparam logic [31:0] RECIP_110  = 32'(TWO_POW_32 / 110);
  localparam logic [31:0] RECIP_72   = 32'(TWO_POW_32 / 72);
  localparam logic [31:0] RECIP_42   = 32'(TWO_POW_32 / 42);
  localparam logic [31:0] RECIP_20   = 32'(TWO_POW_32 / 20);
  localparam logic [31:0] RECIP_6    = 32'(TWO_POW_32 / 6);

  typedef enum logic [2:0] {
    CFG_POS_X,
    CFG_POS_Y,
    CFG_POS_Z,
    CFG_PITCH,
    CFG_YAW,
    CFG_ROLL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ANG_PITCH,
    ANG_YAW,
    ANG_ROLL
  } angle_sel_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic [TAG_W-1:0]          vertex_tag;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] view_x;
    logic signed [COORD_W-1:0] view_y;
    logic signed [COORD_W-1:0] view_z;
    logic [TAG_W-1:0]          view_tag;
    logic                      saturated;
  } view_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } cam_pos_t;

  typedef struct packed {
    logic [ANG_W-1:0] pitch;
    logic [ANG_W-1:0] yaw;
    logic [ANG_W-1:0] roll;
  } angle_set_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cz;
    logic signed [TRIG_W-1:0] sz;
  } trig_t;

  typedef struct packed {
    logic       wr;
    angle_sel_e sel;
  } trig_req_t;

  function automatic logic [7:0] taylor_div(input logic [2:0] step);
    case (step)
      3'd0:    return 8'd156;
      3'd1:    return 8'd110;
      3'd2:    return 8'd72;
      3'd3:    return 8'd42;
      3'd4:    return 8'd20;
      default: return 8'd6;
    endcase
  endfunction

  function automatic logic [31:0] taylor_recip(input logic [2:0] step);
    case (step)
      3'd0:    return RECIP_156;
      3'd1:    return RECIP_110;
      3'd2:    return RECIP_72;
      3'd3:    return RECIP_42;
      3'd4:    return RECIP_20;
      default: return RECIP_6;
    endcase
  endfunction

endpackage

@@ rtl/cvt_trig_gen.sv @@
`timescale 1ns / 1ps
// Sine/cosine generator: sequencer over one shared 32x32 multiplier, and the trig registers.
module cvt_trig_gen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cvt_pkg::trig_req_t    req_i,
  input  cvt_pkg::angle_set_t   angle_i,
  output cvt_pkg::trig_t        trig_o,
  output logic                  busy_o
);

  localparam int F = cvt_pkg::TRIG_FRAC_BITS;
  localparam int TW = cvt_pkg::TRIG_W;
  localparam logic [31:0] RND_HALF = 32'd1 << (29 - F);
  localparam logic [2:0] LAST_STEP = 3'(cvt_pkg::TAYLOR_TERMS - 1);

  typedef enum logic [3:0] {
    TG_IDLE,
    TG_LOAD,
    TG_MUL_R,
    TG_MUL_R2,
    TG_R2,
    TG_MUL_T,
    TG_MUL_Q,
    TG_MUL_D,
    TG_FIX,
    TG_MUL_F,
    TG_ROUND
  } tg_state_e;

  tg_state_e             state_q;
  logic [2:0]            pend_q;
  cvt_pkg::angle_sel_e   sel_q;
  logic                  sin_phase_q;
  logic [31:0]           turn_q;
  logic [30:0]           p_q;
  logic                  neg_q;
  logic [31:0]           r_q;
  logic [31:0]           r2_q;
  logic [30:0]           t_q;
  logic [31:0]           m_q;
  logic [31:0]           qe_q;
  logic [2:0]            step_q;
  logic [63:0]           prod_q;
  cvt_pkg::trig_t        trig_q;

  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           prod_d;
  logic                  pick_vld;
  cvt_pkg::angle_sel_e   pick_sel;
  logic [ cvt_pkg::ANG_W-1:0] pick_ang;
  logic [2:0]            pend_set;
  logic [2:0]            pend_clr;
  logic [31:0]           turn_ld;
  logic [30:0]           p_ld;
  logic [7:0]            div_cur;
  logic [31:0]           rem;
  logic [31:0]           q_fix;
  logic [31:0]           fin;
  logic [31:0]           fin_clamp;
  logic [31:0]           fin_sum;
  logic [F:0]            mag;
  logic signed [TW-1:0]  trig_val;

  always_comb begin
    pick_vld = |pend_q;
    pick_sel = cvt_pkg::ANG_PITCH;
    pick_ang = angle_i.pitch;
    if (pend_q[cvt_pkg::ANG_PITCH]) begin
      pick_sel = cvt_pkg::ANG_PITCH;
      pick_ang = angle_i.pitch;
    end else if (pend_q[cvt_pkg::ANG_YAW]) begin
      pick_sel = cvt_pkg::ANG_YAW;
      pick_ang = angle_i.yaw;
    end else if (pend_q[cvt_pkg::ANG_ROLL]) begin
      pick_sel = cvt_pkg::ANG_ROLL;
      pick_ang = angle_i.roll;
    end
    pend_set = req_i.wr ? (3'b001 << req_i.sel) : 3'b000;
    pend_clr = (state_q == TG_IDLE && pick_vld) ? (3'b001 << pick_sel) : 3'b000;
  end

  always_comb begin
    turn_ld = sin_phase_q ? turn_q : turn_q + cvt_pkg::QUARTER_TURN;
    p_ld    = turn_ld[30] ? 31'(cvt_pkg::Q30_ONE) - {1'b0, turn_ld[29:0]}
                          : {1'b0, turn_ld[29:0]};
    div_cur = cvt_pkg::taylor_div(step_q);
    case (state_q)
      TG_MUL_R: begin
        mul_a = {1'b0, p_q};
        mul_b = cvt_pkg::HALF_PI_Q30;
      end
      TG_MUL_R2: begin
        mul_a = prod_q[61:30];
        mul_b = prod_q[61:30];
      end
      TG_MUL_T: begin
        mul_a = r2_q;
        mul_b = {1'b0, t_q};
      end
      TG_MUL_Q: begin
        mul_a = prod_q[61:30];
        mul_b = cvt_pkg::taylor_recip(step_q);
      end
      TG_MUL_D: begin
        mul_a = prod_q[63:32];
        mul_b = {24'd0, div_cur};
      end
      TG_MUL_F: begin
        mul_a = r_q;
        mul_b = {1'b0, t_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d    = {32'd0, mul_a} * {32'd0, mul_b};
    rem       = m_q - prod_q[31:0];
    q_fix     = qe_q + {31'd0, (rem >= {24'd0, div_cur})};
    fin       = prod_q[61:30];
    fin_clamp = (fin > cvt_pkg::Q30_ONE) ? cvt_pkg::Q30_ONE : fin;
    fin_sum   = fin_clamp + RND_HALF;
    mag       = (F + 1)'(fin_sum >> (30 - F));
    trig_val  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TG_IDLE;
      pend_q      <= '0;
      sel_q       <= cvt_pkg::ANG_PITCH;
      sin_phase_q <= 1'b0;
      turn_q      <= '0;
      p_q         <= '0;
      neg_q       <= 1'b0;
      r_q         <= '0;
      r2_q        <= '0;
      t_q         <= '0;
      m_q         <= '0;
      qe_q        <= '0;
      step_q      <= '0;
      trig_q.cx   <= cvt_pkg::TRIG_ONE;
      trig_q.sx   <= '0;
      trig_q.cy   <= cvt_pkg::TRIG_ONE;
      trig_q.sy   <= '0;
      trig_q.cz   <= cvt_pkg::TRIG_ONE;
      trig_q.sz   <= '0;
    end else begin
      pend_q <= (pend_q & ~pend_clr) | pend_set;
      case (state_q)
        TG_IDLE: begin
          if (pick_vld) begin
            sel_q       <= pick_sel;
            turn_q      <= {pick_ang, 16'd0} & cvt_pkg::ANGLE_MASK;
            sin_phase_q <= 1'b0;
            state_q     <= TG_LOAD;
          end
        end
        TG_LOAD: begin
          p_q     <= p_ld;
          neg_q   <= turn_ld[31];
          state_q <= TG_MUL_R;
        end
        TG_MUL_R: begin
          state_q <= TG_MUL_R2;
        end
        TG_MUL_R2: begin
          r_q     <= prod_q[61:30];
          state_q <= TG_R2;
        end
        TG_R2: begin
          r2_q    <= prod_q[61:30];
          t_q     <= cvt_pkg::Q30_ONE[30:0];
          step_q  <= '0;
          state_q <= TG_MUL_T;
        end
        TG_MUL_T: begin
          state_q <= TG_MUL_Q;
        end
        TG_MUL_Q: begin
          m_q     <= prod_q[61:30];
          state_q <= TG_MUL_D;
        end
        TG_MUL_D: begin
          qe_q    <= prod_q[63:32];
          state_q <= TG_FIX;
        end
        TG_FIX: begin
          t_q <= 31'(cvt_pkg::Q30_ONE - q_fix);
          if (step_q == LAST_STEP) begin
            state_q <= TG_MUL_F;
          end else begin
            step_q  <= step_q + 3'd1;
            state_q <= TG_MUL_T;
          end
        end
        TG_MUL_F: begin
          state_q <= TG_ROUND;
        end
        TG_ROUND: begin
          case (sel_q)
            cvt_pkg::ANG_PITCH: begin
              if (sin_phase_q) trig_q.sx <= trig_val;
              else trig_q.cx <= trig_val;
            end
            cvt_pkg::ANG_YAW: begin
              if (sin_phase_q) trig_q.sy <= trig_val;
              else trig_q.cy <= trig_val;
            end
            default: begin
              if (sin_phase_q) trig_q.sz <= trig_val;
              else trig_q.cz <= trig_val;
            end
          endcase
          if (sin_phase_q) begin
            state_q <= TG_IDLE;
          end else begin
            sin_phase_q <= 1'b1;
            state_q     <= TG_LOAD;
          end
        end
        default: begin
          state_q <= TG_IDLE;
        end
      endcase
    end
  end

  assign trig_o = trig_q;
  assign busy_o = (state_q != TG_IDLE) || (|pend_q);

endmodule

@@ rtl/cvt_rot_pipe.sv @@
`timescale 1ns / 1ps
// Eight-stage vertex pipeline: position subtract, three rotations, saturation.
module cvt_rot_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cvt_pkg::vertex_t   in_i,
  input  cvt_pkg::cam_pos_t  pos_i,
  input  cvt_pkg::trig_t     trig_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cvt_pkg::view_t     out_o
);

  localparam int NS = 8;
  localparam int TW = cvt_pkg::TRIG_W;
  localparam int F  = cvt_pkg::TRIG_FRAC_BITS;
  localparam int DW = 33;
  localparam int AW = 35;
  localparam int BW = 36;
  localparam int VW = 38;
  localparam int PW = TW + BW;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (F - 1);
  localparam logic signed [VW-1:0] SAT_HI = (VW'(1) << 31) - VW'(1);
  localparam logic signed [VW-1:0] SAT_LO = ~((VW'(1) << 31) - VW'(1));

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] s;
    s = v + RND_HALF;
    return s >>> F;
  endfunction

  function automatic logic [32:0] sat(input logic signed [VW-1:0] v);
    if (v > SAT_HI) begin
      return {1'b1, cvt_pkg::COORD_MAX};
    end else if (v < SAT_LO) begin
      return {1'b1, cvt_pkg::COORD_MIN};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  logic [cvt_pkg::TAG_W-1:0] tag_q [NS-1];

  logic signed [DW-1:0]    x0_q, y0_q, z0_q;
  logic signed [TW+DW-1:0] szy1_q, czx1_q, czy1_q, szx1_q;
  logic signed [DW-1:0]    z1_q;
  logic signed [AW-1:0]    a2_q, c2_q;
  logic signed [DW-1:0]    z2_q;
  logic signed [TW+DW-1:0] cyz3_q, syz3_q;
  logic signed [TW+AW-1:0] sya3_q, cya3_q;
  logic signed [AW-1:0]    c3_q;
  logic signed [BW-1:0]    b4_q;
  logic signed [AW-1:0]    c4_q;
  logic signed [VW-1:0]    vx4_q;
  logic signed [TW+BW-1:0] sxb5_q, cxb5_q;
  logic signed [TW+AW-1:0] cxc5_q, sxc5_q;
  logic signed [VW-1:0]    vx5_q;
  logic signed [VW-1:0]    vx6_q, vy6_q, vz6_q;
  cvt_pkg::view_t          view_q;

  logic [32:0]             sat_x, sat_y, sat_z;
  cvt_pkg::view_t          view_d;

  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) tag_q[0] <= in_i.vertex_tag;
    for (int k = 1; k < NS - 1; k++) begin
      if (adv[k]) tag_q[k] <= tag_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      x0_q <= DW'(in_i.vertex_x) - DW'(pos_i.pos_x);
      y0_q <= DW'(in_i.vertex_y) - DW'(pos_i.pos_y);
      z0_q <= DW'(in_i.vertex_z) - DW'(pos_i.pos_z);
    end
    if (adv[1]) begin
      szy1_q <= trig_i.sz * y0_q;
      czx1_q <= trig_i.cz * x0_q;
      czy1_q <= trig_i.cz * y0_q;
      szx1_q <= trig_i.sz * x0_q;
      z1_q   <= z0_q;
    end
    if (adv[2]) begin
      a2_q <= AW'(rnd(PW'(szy1_q)) + rnd(PW'(czx1_q)));
      c2_q <= AW'(rnd(PW'(czy1_q)) - rnd(PW'(szx1_q)));
      z2_q <= z1_q;
    end
    if (adv[3]) begin
      cyz3_q <= trig_i.cy * z2_q;
      sya3_q <= trig_i.sy * a2_q;
      cya3_q <= trig_i.cy * a2_q;
      syz3_q <= trig_i.sy * z2_q;
      c3_q   <= c2_q;
    end
    if (adv[4]) begin
      b4_q  <= BW'(rnd(PW'(cyz3_q)) + rnd(PW'(sya3_q)));
      vx4_q <= VW'(rnd(PW'(cya3_q)) - rnd(PW'(syz3_q)));
      c4_q  <= c3_q;
    end
    if (adv[5]) begin
      sxb5_q <= trig_i.sx * b4_q;
      cxc5_q <= trig_i.cx * c4_q;
      cxb5_q <= trig_i.cx * b4_q;
      sxc5_q <= trig_i.sx * c4_q;
      vx5_q  <= vx4_q;
    end
    if (adv[6]) begin
      vy6_q <= VW'(rnd(PW'(sxb5_q)) + rnd(PW'(cxc5_q)));
      vz6_q <= VW'(rnd(PW'(cxb5_q)) - rnd(PW'(sxc5_q)));
      vx6_q <= vx5_q;
    end
    if (adv[7]) begin
      view_q <= view_d;
    end
  end

  always_comb begin
    sat_x            = sat(vx6_q);
    sat_y            = sat(vy6_q);
    sat_z            = sat(vz6_q);
    view_d.view_x    = sat_x[31:0];
    view_d.view_y    = sat_y[31:0];
    view_d.view_z    = sat_z[31:0];
    view_d.view_tag  = tag_q[NS-2];
    view_d.saturated = sat_x[32] | sat_y[32] | sat_z[32];
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NS-1];
  assign out_o       = view_q;

endmodule

@@ rtl/camera_view_transform.sv @@
`timescale 1ns / 1ps
// Top level of the camera view transform: register port, trig generator and vertex pipeline.
//
//  Channel | Dir | Handshake                      | Payload
//  vert    | in  | vert_valid_i / vert_stall_o    | cvt_pkg::vertex_t
//  view    | out | view_valid_o / view_stall_i    | cvt_pkg::view_t
//  config  | in  | psel, penable, pwrite, pready  | pwdata at paddr = 4 * register index
//
//  One vertex per clock while vert_stall_o is low; its result passes 8 register stages after acceptance.
//  An angle write runs the trig generator on one shared 32x32 multiplier,
//  with vert_stall_o high until the new sine and cosine are in the trig registers.
//  Reset: position and angles zero, cosines 1.0, sines 0, pipeline empty.
//  A view stall holds the valid stages back to the nearest bubble; bubbles collapse first.
module camera_view_transform (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cvt_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        vert_valid_i,
  output logic                        vert_stall_o,
  input  cvt_pkg::vertex_t            vert_i,
  output logic                        view_valid_o,
  input  logic                        view_stall_i,
  output cvt_pkg::view_t              view_o
);

  cvt_pkg::cam_pos_t    pos_q;
  cvt_pkg::angle_set_t  ang_q;
  cvt_pkg::cfg_reg_e    reg_idx;
  cvt_pkg::trig_req_t   trig_req;
  cvt_pkg::trig_t       trig;
  logic                 apb_wr;
  logic                 trig_busy;
  logic                 pipe_stall;
  logic                 pipe_valid;

  assign reg_idx = cvt_pkg::cfg_reg_e'(paddr[cvt_pkg::APB_AW-1:2]);
  assign apb_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ang_q <= '0;
    end else if (apb_wr) begin
      case (reg_idx)
        cvt_pkg::CFG_POS_X: pos_q.pos_x <= pwdata;
        cvt_pkg::CFG_POS_Y: pos_q.pos_y <= pwdata;
        cvt_pkg::CFG_POS_Z: pos_q.pos_z <= pwdata;
        cvt_pkg::CFG_PITCH: ang_q.pitch <= pwdata[cvt_pkg::ANG_W-1:0];
        cvt_pkg::CFG_YAW:   ang_q.yaw   <= pwdata[cvt_pkg::ANG_W-1:0];
        cvt_pkg::CFG_ROLL:  ang_q.roll  <= pwdata[cvt_pkg::ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    trig_req.wr  = 1'b0;
    trig_req.sel = cvt_pkg::ANG_PITCH;
    if (apb_wr) begin
      case (reg_idx)
        cvt_pkg::CFG_PITCH: begin
          trig_req.wr  = 1'b1;
          trig_req.sel = cvt_pkg::ANG_PITCH;
        end
        cvt_pkg::CFG_YAW: begin
          trig_req.wr  = 1'b1;
          trig_req.sel = cvt_pkg::ANG_YAW;
        end
        cvt_pkg::CFG_ROLL: begin
          trig_req.wr  = 1'b1;
          trig_req.sel = cvt_pkg::ANG_ROLL;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cvt_pkg::CFG_POS_X: prdata = pos_q.pos_x;
      cvt_pkg::CFG_POS_Y: prdata = pos_q.pos_y;
      cvt_pkg::CFG_POS_Z: prdata = pos_q.pos_z;
      cvt_pkg::CFG_PITCH: prdata = {16'd0, ang_q.pitch};
      cvt_pkg::CFG_YAW:   prdata = {16'd0, ang_q.yaw};
      cvt_pkg::CFG_ROLL:  prdata = {16'd0, ang_q.roll};
      default:            prdata = '0;
    endcase
  end

  cvt_trig_gen u_trig_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (trig_req),
    .angle_i (ang_q),
    .trig_o  (trig),
    .busy_o  (trig_busy)
  );

  assign pipe_valid   = vert_valid_i && !trig_busy;
  assign vert_stall_o = trig_busy || pipe_stall;

  cvt_rot_pipe u_rot_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pipe_valid),
    .in_stall_o  (pipe_stall),
    .in_i        (vert_i),
    .pos_i       (pos_q),
    .trig_i      (trig),
    .out_valid_o (view_valid_o),
    .out_stall_i (view_stall_i),
    .out_o       (view_o)
  );

  a_angle_wr_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apb_wr && (reg_idx == cvt_pkg::CFG_PITCH || reg_idx == cvt_pkg::CFG_YAW ||
               reg_idx == cvt_pkg::CFG_ROLL) |=> vert_stall_o)
    else $error("angle write did not stall the vertex input");

  a_pos_wr_no_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apb_wr && !trig_busy && (reg_idx == cvt_pkg::CFG_POS_X ||
    reg_idx == cvt_pkg::CFG_POS_Y || reg_idx == cvt_pkg::CFG_POS_Z) |=> !trig_busy)
    else $error("position write started the trig generator");

  a_sat_flag_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    view_valid_o && view_o.saturated |->
      (view_o.view_x == cvt_pkg::COORD_MAX || view_o.view_x == cvt_pkg::COORD_MIN ||
       view_o.view_y == cvt_pkg::COORD_MAX || view_o.view_y == cvt_pkg::COORD_MIN ||
       view_o.view_z == cvt_pkg::COORD_MAX || view_o.view_z == cvt_pkg::COORD_MIN))
    else $error("saturated flag set without a clipped coordinate");

endmodule
